// File: hw/rtl/rgb_to_hsv_hue_offset_defines.svh
// Assertion macros used by the back end (rhh_back) of the pixel converter.
`ifndef RGB_TO_HSV_HUE_OFFSET_DEFINES_SVH
`define RGB_TO_HSV_HUE_OFFSET_DEFINES_SVH

`ifndef ASSERT_OFF
`define RHH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RHH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define RHH_ASSERT(lbl, clk, rst_n, prop)
`define RHH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/rhh_pkg.sv
package rhh_pkg;

    localparam logic [8:0] OFFSET_RESET = 9'd40;
    localparam logic [8:0] DEG_WRAP     = 9'd360;
    localparam int unsigned DIV_STEPS   = 8;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // One classified pixel as it waits between front and back.
    typedef struct packed {
        logic [7:0]        value;
        logic [7:0]        delta;
        logic signed [8:0] diff;
        t_sector           sector;
    } t_cls;

    typedef struct packed {
        logic               grey;
        logic [7:0]         value;
        logic [15:0]        sat_num;
        logic signed [18:0] num;
        logic [16:0]        full;
        logic [12:0]        hue_den;
    } t_mid;

    typedef struct packed {
        logic        grey;
        logic [7:0]  value;
        logic [15:0] sat_rem;
        logic [7:0]  sat_q;
        logic [20:0] hue_rem;
        logic [7:0]  hue_q;
        logic [12:0] hue_den;
    } t_div;

    function automatic logic [8:0] sector_base(input t_sector s);
        logic [8:0] b;
        case (s)
            SEC_RED:   b = 9'd0;
            SEC_GREEN: b = 9'd120;
            SEC_BLUE:  b = 9'd240;
            default:   b = 9'd0;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/rhh_if.sv
interface rhh_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, blue, green, red, input ready);
    modport sink   (input valid, blue, green, red, output ready);
endinterface

interface rhh_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [7:0] saturation;
    logic [7:0] hue;
    modport source (output valid, value, saturation, hue, input ready);
    modport sink   (input valid, value, saturation, hue, output ready);
endinterface

// File: hw/rtl/rgb_to_hsv_hue_offset.sv
// Converts one 8-bit blue, green, red pixel per transfer into value, saturation
// and hue (hue offset by a programmable number of degrees, then scaled to 0..254).
// A new pixel can be taken every cycle unless the output stalls; each pixel passes
// through the queue, a middle stage and the two eight-step restoring dividers
// that run one quotient bit per pipeline stage. The offset register resets
// to 40 degrees; writes of 360 or more are reduced by 360, and it should be
// written only while no pixel is in flight.
module rgb_to_hsv_hue_offset
    import rhh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    rhh_pix_if.sink    i_pix,
    rhh_hsv_if.source  o_hsv
);

    logic [8:0] r_offset;
    logic [8:0] n_offset;
    t_cls       front_cls;
    t_cls       q_cls;
    logic       q_ready;
    logic       q_valid;
    logic       take;

    always_comb begin
        if (i_cfg_wdata >= DEG_WRAP) begin
            n_offset = i_cfg_wdata - DEG_WRAP;
        end else begin
            n_offset = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= n_offset;
        end
    end

    assign i_pix.ready = q_ready;

    rhh_front u_front (
        .i_blue  (i_pix.blue),
        .i_green (i_pix.green),
        .i_red   (i_pix.red),
        .o_cls   (front_cls)
    );

    rhh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_pix.valid && q_ready),
        .i_data  (front_cls),
        .o_ready (q_ready),
        .i_pop   (take),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    rhh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_offset (r_offset),
        .i_valid  (q_valid),
        .i_cls    (q_cls),
        .o_take   (take),
        .o_hsv    (o_hsv)
    );

endmodule

// File: hw/rtl/rhh_front.sv
module rhh_front
    import rhh_pkg::*;
(
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    output t_cls       o_cls
);

    logic [7:0] mx;
    logic [7:0] mn;

    always_comb begin
        mx = i_red;
        if (i_green > mx) begin
            mx = i_green;
        end
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
    end

    // Red wins ties, then green, as in the sector rule.
    always_comb begin
        o_cls.value = mx;
        o_cls.delta = mx - mn;
        if (i_red == mx) begin
            o_cls.sector = SEC_RED;
            o_cls.diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green == mx) begin
            o_cls.sector = SEC_GREEN;
            o_cls.diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            o_cls.sector = SEC_BLUE;
            o_cls.diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

endmodule

// File: hw/rtl/rhh_queue.sv
module rhh_queue
    import rhh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    t_cls       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hw/rtl/rhh_back.sv
`include "rgb_to_hsv_hue_offset_defines.svh"

module rhh_back
    import rhh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [8:0]       i_offset,
    input  logic             i_valid,
    input  t_cls             i_cls,
    output logic             o_take,
    rhh_hsv_if.source        o_hsv
);

    t_mid r_mid;
    logic r_mid_v;
    t_div r_div [DIV_STEPS + 1];
    logic r_div_v [DIV_STEPS + 1];
    t_mid n_mid;
    t_div n_div [DIV_STEPS + 1];
    logic en;

    function automatic t_div div_step(input t_div d, input int unsigned pos);
        t_div        o;
        logic [15:0] s_sh;
        logic [20:0] h_sh;
        o    = d;
        s_sh = 16'(d.value) << pos;
        h_sh = 21'(d.hue_den) << pos;
        if (d.sat_rem >= s_sh) begin
            o.sat_rem  = d.sat_rem - s_sh;
            o.sat_q[pos[2:0]] = 1'b1;
        end
        if (d.hue_rem >= h_sh) begin
            o.hue_rem  = d.hue_rem - h_sh;
            o.hue_q[pos[2:0]] = 1'b1;
        end
        return o;
    endfunction

    // The whole pipeline moves together whenever the output slot is empty or being taken.
    assign en     = !r_div_v[DIV_STEPS] || o_hsv.ready;
    assign o_take = en;

    always_comb begin
        logic [9:0]         base_deg;
        logic [17:0]        prod;
        logic signed [15:0] diffx;
        logic signed [15:0] d60;
        base_deg = {1'b0, sector_base(i_cls.sector)} + {1'b0, i_offset};
        prod     = 18'(base_deg) * 18'(i_cls.delta);
        diffx    = 16'(i_cls.diff);
        d60      = (diffx <<< 6) - (diffx <<< 2);
        n_mid.grey    = (i_cls.delta == 8'd0);
        n_mid.value   = i_cls.value;
        n_mid.sat_num = {i_cls.delta, 8'd0} - {8'd0, i_cls.delta};
        n_mid.num     = 19'(d60) + $signed({1'b0, prod});
        n_mid.full    = 17'(i_cls.delta) * 17'(DEG_WRAP);
        n_mid.hue_den = 13'(i_cls.delta) * 13'd24;
    end

    // Hue in degrees times delta is wrapped once, then scaled by 17/24.
    always_comb begin
        logic signed [18:0] fulls;
        logic signed [18:0] w;
        logic [16:0]        wu;
        fulls = $signed({2'b0, r_mid.full});
        if (r_mid.num < 0) begin
            w = r_mid.num + fulls;
        end else if (r_mid.num >= fulls) begin
            w = r_mid.num - fulls;
        end else begin
            w = r_mid.num;
        end
        wu = w[16:0];
        n_div[0].grey    = r_mid.grey;
        n_div[0].value   = r_mid.value;
        n_div[0].sat_rem = r_mid.sat_num;
        n_div[0].sat_q   = 8'd0;
        n_div[0].hue_rem = {wu, 4'd0} + 21'(wu);
        n_div[0].hue_q   = 8'd0;
        n_div[0].hue_den = r_mid.hue_den;
        for (int unsigned k = 0; k < DIV_STEPS; k++) begin
            n_div[k + 1] = div_step(r_div[k], DIV_STEPS - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
            for (int unsigned k = 0; k <= DIV_STEPS; k++) begin
                r_div_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_mid_v    <= i_valid;
            r_div_v[0] <= r_mid_v;
            for (int unsigned k = 0; k < DIV_STEPS; k++) begin
                r_div_v[k + 1] <= r_div_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid <= n_mid;
            for (int unsigned k = 0; k <= DIV_STEPS; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    assign o_hsv.valid      = r_div_v[DIV_STEPS];
    assign o_hsv.value      = r_div[DIV_STEPS].value;
    assign o_hsv.saturation = r_div[DIV_STEPS].grey ? 8'd0 : r_div[DIV_STEPS].sat_q;
    assign o_hsv.hue        = r_div[DIV_STEPS].grey ? 8'd0 : r_div[DIV_STEPS].hue_q;

    `RHH_ASSERT_NEVER(a_hue_range, i_clk, i_rst_n, o_hsv.valid && (o_hsv.hue == 8'hFF))
    `RHH_ASSERT(a_zero_value, i_clk, i_rst_n, (o_hsv.valid && o_hsv.value == 8'd0) |-> (o_hsv.saturation == 8'd0 && o_hsv.hue == 8'd0))
    `RHH_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_hsv.valid && !o_hsv.ready) |=> (o_hsv.valid && $stable(o_hsv.hue) && $stable(o_hsv.saturation)))

endmodule

// File: bench/rgb_to_hsv_hue_offset_chk.sv
module rgb_to_hsv_hue_offset_chk
    import rhh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic        i_hsv_valid,
    input  logic        i_hsv_ready,
    input  logic [7:0]  i_value,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_hue,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] saturation;
        logic [7:0] hue;
    } t_hsv;

    t_hsv       hsv_expected[$];
    logic [8:0] offset_deg;

    function automatic t_hsv convert_pixel(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r, input logic [8:0] offs);
        int   mx, mn, delta, base, diff, num, full;
        t_hsv res;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res.value = mx[7:0];
        res.saturation = '0;
        res.hue = '0;
        if (delta != 0) begin
            res.saturation = 8'((255 * delta) / mx);
            if (r == mx) begin
                base = 0;
                diff = int'(g) - int'(b);
            end else if (g == mx) begin
                base = 120;
                diff = int'(b) - int'(r);
            end else begin
                base = 240;
                diff = int'(r) - int'(g);
            end
            num = base * delta + 60 * diff + int'(offs) * delta;
            full = 360 * delta;
            if (num < 0) num += full;
            else if (num >= full) num -= full;
            res.hue = 8'((num * 255) / full);
        end
        return res;
    endfunction

    assign o_pending = hsv_expected.size();

    always @(posedge i_clk) begin
        t_hsv want;
        if (!i_rst_n) begin
            offset_deg <= OFFSET_RESET;
            o_errors   <= 0;
            o_results  <= 0;
        end else begin
            if (i_cfg_we)
                offset_deg <= (i_cfg_wdata >= DEG_WRAP) ? i_cfg_wdata - DEG_WRAP
                                                        : i_cfg_wdata;
            if (i_pix_valid && i_pix_ready)
                hsv_expected.push_back(convert_pixel(i_blue, i_green, i_red, offset_deg));
            if (i_hsv_valid && i_hsv_ready) begin
                o_results <= o_results + 1;
                if (hsv_expected.size() == 0) begin
                    $display("%0t: unexpected result v=%0d s=%0d h=%0d", $time,
                             i_value, i_saturation, i_hue);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hsv_expected.pop_front();
                    if (want !== {i_value, i_saturation, i_hue}) begin
                        $display("%0t: mismatch expected v=%0d s=%0d h=%0d, got v=%0d s=%0d h=%0d",
                                 $time, want.value, want.saturation, want.hue,
                                 i_value, i_saturation, i_hue);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/rgb_to_hsv_hue_offset_tb.sv
module rgb_to_hsv_hue_offset_tb;
    localparam int LATENCY = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;
    int         errors, pending, results;
    int         idle_cycles = 0;
    int         pixels_sent = 0;

    rhh_pix_if pix ();
    rhh_hsv_if hsv ();

    rgb_to_hsv_hue_offset u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_pix      (pix),
        .o_hsv      (hsv)
    );

    rgb_to_hsv_hue_offset_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_pix_valid(pix.valid), .i_pix_ready(pix.ready),
        .i_blue(pix.blue), .i_green(pix.green), .i_red(pix.red),
        .i_hsv_valid(hsv.valid), .i_hsv_ready(hsv.ready),
        .i_value(hsv.value), .i_saturation(hsv.saturation), .i_hue(hsv.hue),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        pix.valid = 1'b0;
        pix.blue = '0;
        pix.green = '0;
        pix.red = '0;
        hsv.ready = 1'b0;
    end

    // Watchdog: counts cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sink side: random stalls before each result, with calm stretches.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            repeat (gap) begin
                hsv.ready <= 1'b0;
                @(posedge i_clk);
            end
            hsv.ready <= 1'b1;
            @(posedge i_clk iff hsv.valid);
        end
    end

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.blue  <= b;
        pix.green <= g;
        pix.red   <= r;
        @(posedge i_clk iff pix.ready);
        pixels_sent++;
    endtask

    task automatic drain_and_idle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [8:0] deg);
        cfg_we    <= 1'b1;
        cfg_wdata <= deg;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [8:0] offsets[7] = '{9'd0, 9'd359, 9'd360, 9'd511, 9'd180, 9'd1, 9'd40};
        logic [7:0] v;
        bit         burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at the reset offset: greys, ties between channels,
        // each sector and negative channel differences that need a wrap.
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 0);
        send_pixel(8'd0, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd0, 0);
        send_pixel(8'd1, 8'd0, 8'd255, 0);
        send_pixel(8'd255, 8'd254, 8'd1, 0);
        send_pixel(8'd0, 8'd1, 8'd1, 0);
        send_pixel(8'd170, 8'd85, 8'd255, 1);
        send_pixel(8'd1, 8'd0, 8'd0, 1);
        send_pixel(8'd128, 8'd127, 8'd64, 1);
        // The sender holds off here until every result is back.
        drain_and_idle();

        foreach (offsets[k]) begin
            write_offset(offsets[k]);
            send_pixel(8'd255, 8'd0, 8'd1, 0);
            send_pixel(8'd0, 8'd255, 8'd254, 0);
            repeat (70) begin
                burst = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 4))
                    0: begin
                        v = 8'($urandom);
                        send_pixel(v, v, v, burst);
                    end
                    1: send_pixel(8'($urandom_range(250, 255)), 8'($urandom_range(0, 5)),
                                  8'($urandom), burst);
                    default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), burst);
                endcase
            end
            drain_and_idle();
        end

        $display("Sent %0d pixels across %0d hue offsets, %0d results checked.",
                 pixels_sent, $size(offsets) + 1, results);
        $display("Covered greys, channel ties, all sectors, wrap in both directions.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
